FILE: rtl/tmpg_pkg.sv
// ----------------------------------------------------------------------------
// tmpg_pkg: shared types and constants of the ternary multi-probe generator
// Holds trit codes, command and kind codes, the phase type and the result
// record that travels from the step logic to the output stage.
// ----------------------------------------------------------------------------
package tmpg_pkg;

    // Widths fixed by the item layout.
    localparam int SIG_W   = 64;
    localparam int CFG_W   = 6;
    localparam int RAD_W   = 2;
    localparam int KIND_W  = 2;
    localparam int IN_TDATA_W = 72;

    // Reset value of the trit-count register.
    localparam logic [CFG_W-1:0] TRITS_RESET = 6'd32;

    // Trit codes: two bits per trit, both 00 and 11 read as zero.
    localparam logic [1:0] CODE_ZERO = 2'b00;
    localparam logic [1:0] CODE_POS  = 2'b01;
    localparam logic [1:0] CODE_NEG  = 2'b10;

    // Command carried with each input item.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // Probe radius codes.
    localparam logic [RAD_W-1:0] RADIUS_QUERY  = 2'd0;
    localparam logic [RAD_W-1:0] RADIUS_SINGLE = 2'd1;
    localparam logic [RAD_W-1:0] RADIUS_PAIR   = 2'd2;

    // Kind of a result item.
    typedef enum logic [KIND_W-1:0] {
        KIND_PROBE = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_HIT   = 2'd2
    } kind_t;

    // Enumeration phase.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SINGLE = 2'd1,
        PH_PAIR   = 2'd2,
        PH_QUERY  = 2'd3
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [SIG_W-1:0] probe;
        kind_t            kind;
    } result_t;

endpackage

FILE: rtl/ternary_multiprobe_generator.sv
// ----------------------------------------------------------------------------
// ternary_multiprobe_generator: multi-probe neighbour enumerator, radius 2
// Walks the ternary neighbours of a latched query signature, one per item.
// ----------------------------------------------------------------------------
// Every input item yields exactly one result item, registered in the output
// register or, while it is full, in the skid stage; it waits there while the
// receiver stalls. A start item (tuser 0) latches a query and radius and
// returns the first probe; each advance item (tuser 1) returns the next probe,
// or an end marker: kind 1 when the neighbours run out, kind 2 when prior_hit
// reports a match. The block takes one item per clock cycle: the next-probe
// selection (priority encoders over the trits, then the trit rewrite) sits in
// one pass between the enumeration state and the output register, and a
// one-item skid stage keeps the input open for one more item while a result
// waits downstream; after that the input stalls until the receiver takes a
// result. The trit-count register is written over its own channel, which is
// always ready, and is saturated to MAX_TRITS; write it only while no item is
// in flight.
module ternary_multiprobe_generator #(
    parameter int MAX_TRITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration: trits_in_use.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmpg_pkg::CFG_W-1:0]          cfg_data,
    // Input items.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata: query_signature[63:0], probe_radius[65:64], prior_hit[66], zero[71:67]
    input  logic [tmpg_pkg::IN_TDATA_W-1:0]     s_tdata,
    // tuser: cmd[0]
    input  logic                                s_tuser,
    // Result items.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata: probe_signature[63:0]
    output logic [tmpg_pkg::SIG_W-1:0]          m_tdata,
    // tuser: result_kind[1:0]
    output logic [tmpg_pkg::KIND_W-1:0]         m_tuser
);

    localparam int PW = $clog2(MAX_TRITS);
    localparam int CW = $clog2(MAX_TRITS + 1);

    logic [tmpg_pkg::CFG_W-1:0] trits_reg;
    logic [CW-1:0]              active_trits;
    logic                       accept;
    tmpg_pkg::result_t          step_result;
    tmpg_pkg::result_t          out_result;

    // Trit-count register; the write channel never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trits_reg <= tmpg_pkg::TRITS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            trits_reg <= cfg_data;
        end
    end

    // Counts above the trit capacity saturate.
    assign active_trits = (trits_reg > tmpg_pkg::CFG_W'(MAX_TRITS)) ?
                          CW'(MAX_TRITS) : trits_reg[CW-1:0];

    assign accept = s_tvalid && s_tready;

    // Enumeration state and next-probe selection.
    tmpg_step #(
        .MAX_TRITS (MAX_TRITS),
        .PW        (PW),
        .CW        (CW)
    ) u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .cmd          (s_tuser),
        .query        (s_tdata[63:0]),
        .radius       (s_tdata[65:64]),
        .prior_hit    (s_tdata[66]),
        .active_trits (active_trits),
        .result       (step_result)
    );

    // Output register and skid stage.
    tmpg_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = out_result.probe;
    assign m_tuser = out_result.kind;

`ifndef SYNTH
    // The input only closes while a result is held at the output.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty output register");

    // No result kind beyond match.
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == tmpg_pkg::KIND_PROBE) ||
                     (m_tuser == tmpg_pkg::KIND_DONE) ||
                     (m_tuser == tmpg_pkg::KIND_HIT))
        else $error("illegal result kind");

    // End markers carry a zero signature.
    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != tmpg_pkg::KIND_PROBE)) |-> (m_tdata == '0))
        else $error("end marker with nonzero signature");

    // An accepted item with a free output shows up in the next cycle.
    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("accepted item did not reach the output");
`endif

endmodule

FILE: rtl/tmpg_step.sv
// ----------------------------------------------------------------------------
// tmpg_step: enumeration state and next-probe logic
// Holds the latched query and the enumeration cursor, and for each accepted
// item computes the next cursor and the probe it selects in one pass.
// ----------------------------------------------------------------------------
module tmpg_step #(
    parameter int MAX_TRITS = 32,
    parameter int PW = $clog2(MAX_TRITS),
    parameter int CW = $clog2(MAX_TRITS + 1)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic                           cmd,
    input  logic [tmpg_pkg::SIG_W-1:0]     query,
    input  logic [tmpg_pkg::RAD_W-1:0]     radius,
    input  logic                           prior_hit,
    input  logic [CW-1:0]                  active_trits,
    output tmpg_pkg::result_t              result
);

    // Enumeration state.
    logic [tmpg_pkg::SIG_W-1:0] held_query_reg, held_query_next;
    logic [tmpg_pkg::RAD_W-1:0] held_radius_reg, held_radius_next;
    tmpg_pkg::phase_t           phase_reg, phase_next;
    logic [PW-1:0]              first_pos_reg, first_pos_next;
    logic [PW-1:0]              second_pos_reg, second_pos_next;
    logic                       first_choice_reg, first_choice_next;
    logic                       second_choice_reg, second_choice_next;

    logic                       start;
    logic [tmpg_pkg::SIG_W-1:0] qsel;
    logic [MAX_TRITS-1:0]       trit_zero;
    logic [MAX_TRITS-1:0]       any_vec;
    logic [MAX_TRITS-1:0]       nz_vec;
    logic                       any_found;
    logic                       nz_found;
    logic [PW-1:0]              any_pos;
    logic [PW-1:0]              nz_pos;
    logic                       pairs_ok;
    logic [CW:0]                second_inc;
    logic [CW:0]                first_inc2;
    logic                       ok;
    logic                       hit;
    logic [tmpg_pkg::SIG_W-1:0] probe;

    assign start = (cmd == tmpg_pkg::CMD_START);

    // The query in use: the incoming one on start, the held one otherwise.
    assign qsel = start ? query : held_query_reg;

    // Per-trit zero flags and candidate masks for the position scans.
    always_comb begin
        for (int j = 0; j < MAX_TRITS; j++) begin
            trit_zero[j] = (qsel[2*j +: 2] != tmpg_pkg::CODE_POS) &&
                           (qsel[2*j +: 2] != tmpg_pkg::CODE_NEG);
            any_vec[j]   = (CW'(j) < active_trits) &&
                           (start || (PW'(j) > first_pos_reg));
            nz_vec[j]    = any_vec[j] && !trit_zero[j];
        end
    end

    // Priority encoders: lowest candidate position wins.
    always_comb begin
        any_pos = '0;
        nz_pos  = '0;
        for (int j = MAX_TRITS - 1; j >= 0; j--) begin
            if (any_vec[j]) begin
                any_pos = PW'(j);
            end
            if (nz_vec[j]) begin
                nz_pos = PW'(j);
            end
        end
    end

    assign any_found  = |any_vec;
    assign nz_found   = |nz_vec;
    assign pairs_ok   = (active_trits >= CW'(2));
    assign second_inc = (CW+1)'(second_pos_reg) + (CW+1)'(1);
    assign first_inc2 = (CW+1)'(first_pos_reg) + (CW+1)'(2);

    // Next enumeration state for the accepted item.
    always_comb begin
        held_query_next    = held_query_reg;
        held_radius_next   = held_radius_reg;
        phase_next         = phase_reg;
        first_pos_next     = first_pos_reg;
        second_pos_next    = second_pos_reg;
        first_choice_next  = first_choice_reg;
        second_choice_next = second_choice_reg;
        ok  = 1'b0;
        hit = 1'b0;
        if (accept) begin
            if (start) begin
                held_query_next    = query;
                held_radius_next   = radius;
                first_pos_next     = '0;
                second_pos_next    = '0;
                first_choice_next  = 1'b0;
                second_choice_next = 1'b0;
                unique case (radius)
                    tmpg_pkg::RADIUS_QUERY: begin
                        phase_next = tmpg_pkg::PH_QUERY;
                        ok = 1'b1;
                    end
                    tmpg_pkg::RADIUS_SINGLE: begin
                        if (any_found) begin
                            phase_next     = tmpg_pkg::PH_SINGLE;
                            first_pos_next = any_pos;
                            ok = 1'b1;
                        end
                    end
                    tmpg_pkg::RADIUS_PAIR: begin
                        if (nz_found) begin
                            phase_next     = tmpg_pkg::PH_SINGLE;
                            first_pos_next = nz_pos;
                            ok = 1'b1;
                        end else if (pairs_ok) begin
                            phase_next      = tmpg_pkg::PH_PAIR;
                            first_pos_next  = PW'(0);
                            second_pos_next = PW'(1);
                            ok = 1'b1;
                        end
                    end
                    default: begin
                        ok = 1'b0;
                    end
                endcase
            end else if (phase_reg == tmpg_pkg::PH_IDLE) begin
                ok = 1'b0;
            end else if (prior_hit) begin
                hit = 1'b1;
            end else begin
                unique case (phase_reg)
                    tmpg_pkg::PH_SINGLE: begin
                        if (held_radius_reg == tmpg_pkg::RADIUS_SINGLE) begin
                            // Zero trit: +1 first, then -1, then next position.
                            if (!first_choice_reg && trit_zero[first_pos_reg]) begin
                                first_choice_next = 1'b1;
                                ok = 1'b1;
                            end else if (any_found) begin
                                first_pos_next    = any_pos;
                                first_choice_next = 1'b0;
                                ok = 1'b1;
                            end
                        end else begin
                            // Sign flips run out, then the pair moves begin.
                            if (nz_found) begin
                                first_pos_next    = nz_pos;
                                first_choice_next = 1'b0;
                                ok = 1'b1;
                            end else if (pairs_ok) begin
                                phase_next         = tmpg_pkg::PH_PAIR;
                                first_pos_next     = PW'(0);
                                second_pos_next    = PW'(1);
                                first_choice_next  = 1'b0;
                                second_choice_next = 1'b0;
                                ok = 1'b1;
                            end
                        end
                    end
                    tmpg_pkg::PH_PAIR: begin
                        if (!second_choice_reg && trit_zero[second_pos_reg]) begin
                            second_choice_next = 1'b1;
                            ok = 1'b1;
                        end else if (!first_choice_reg && trit_zero[first_pos_reg]) begin
                            first_choice_next  = 1'b1;
                            second_choice_next = 1'b0;
                            ok = 1'b1;
                        end else begin
                            first_choice_next  = 1'b0;
                            second_choice_next = 1'b0;
                            if (second_inc < {1'b0, active_trits}) begin
                                second_pos_next = second_inc[PW-1:0];
                                ok = 1'b1;
                            end else if (first_inc2 < {1'b0, active_trits}) begin
                                first_pos_next  = first_pos_reg + PW'(1);
                                second_pos_next = first_inc2[PW-1:0];
                                ok = 1'b1;
                            end
                        end
                    end
                    tmpg_pkg::PH_QUERY: begin
                        ok = 1'b0;
                    end
                    default: begin
                        ok = 1'b0;
                    end
                endcase
            end
            if (!ok) begin
                phase_next = tmpg_pkg::PH_IDLE;
            end
        end
    end

    // Probe built from the next state: rewrite the trits at the cursor.
    always_comb begin
        probe = qsel;
        for (int j = 0; j < MAX_TRITS; j++) begin
            if (phase_next == tmpg_pkg::PH_SINGLE && PW'(j) == first_pos_next) begin
                if (held_radius_next == tmpg_pkg::RADIUS_SINGLE) begin
                    probe[2*j +: 2] = trit_zero[j] ?
                        (first_choice_next ? tmpg_pkg::CODE_NEG : tmpg_pkg::CODE_POS) :
                        tmpg_pkg::CODE_ZERO;
                end else begin
                    probe[2*j +: 2] = (qsel[2*j +: 2] == tmpg_pkg::CODE_POS) ?
                        tmpg_pkg::CODE_NEG : tmpg_pkg::CODE_POS;
                end
            end else if (phase_next == tmpg_pkg::PH_PAIR && PW'(j) == first_pos_next) begin
                probe[2*j +: 2] = trit_zero[j] ?
                    (first_choice_next ? tmpg_pkg::CODE_NEG : tmpg_pkg::CODE_POS) :
                    tmpg_pkg::CODE_ZERO;
            end else if (phase_next == tmpg_pkg::PH_PAIR && PW'(j) == second_pos_next) begin
                probe[2*j +: 2] = trit_zero[j] ?
                    (second_choice_next ? tmpg_pkg::CODE_NEG : tmpg_pkg::CODE_POS) :
                    tmpg_pkg::CODE_ZERO;
            end
        end
    end

    // Result item: a probe, or an end marker with a zero signature.
    always_comb begin
        if (hit) begin
            result.probe = '0;
            result.kind  = tmpg_pkg::KIND_HIT;
        end else if (ok) begin
            result.probe = probe;
            result.kind  = tmpg_pkg::KIND_PROBE;
        end else begin
            result.probe = '0;
            result.kind  = tmpg_pkg::KIND_DONE;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_query_reg    <= '0;
            held_radius_reg   <= '0;
            phase_reg         <= tmpg_pkg::PH_IDLE;
            first_pos_reg     <= '0;
            second_pos_reg    <= '0;
            first_choice_reg  <= 1'b0;
            second_choice_reg <= 1'b0;
        end else begin
            held_query_reg    <= held_query_next;
            held_radius_reg   <= held_radius_next;
            phase_reg         <= phase_next;
            first_pos_reg     <= first_pos_next;
            second_pos_reg    <= second_pos_next;
            first_choice_reg  <= first_choice_next;
            second_choice_reg <= second_choice_next;
        end
    end

endmodule

FILE: rtl/tmpg_out_skid.sv
// ----------------------------------------------------------------------------
// tmpg_out_skid: output register with skid stage
// Registers each result item and parks one more item while the downstream
// side stalls, so the input side can keep accepting.
// ----------------------------------------------------------------------------
module tmpg_out_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  tmpg_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tmpg_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    tmpg_pkg::result_t out_data_reg, out_data_next;
    tmpg_pkg::result_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Refill the output from the skid stage first, else from the input.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_data_next  = in_data;
                out_valid_next = in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    // Control flags are reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

FILE: sim/ternary_multiprobe_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_multiprobe_generator_tb: self-checking bench for the probe generator
// Drives start and advance items over the input stream and checks every result
// item against an in-bench neighbour enumerator. It covers a directed opening,
// then random query runs under several trit-count settings, with bursty input
// and a stalling receiver.
// ----------------------------------------------------------------------------
module ternary_multiprobe_generator_tb;

    localparam int TRIT_LIMIT   = 32;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 150;

    // One input item as the bench sees it.
    typedef struct packed {
        logic                       cmd;
        logic [tmpg_pkg::SIG_W-1:0] signature;
        logic [tmpg_pkg::RAD_W-1:0] radius;
        logic                       prior_hit;
    } query_item_t;

    // Receiver stall styles.
    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,
        RX_COIN   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_MOSTLY = 2'd3
    } rx_style_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [tmpg_pkg::CFG_W-1:0]      cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tmpg_pkg::IN_TDATA_W-1:0] s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tmpg_pkg::SIG_W-1:0]      m_tdata;
    logic [tmpg_pkg::KIND_W-1:0]     m_tuser;

    query_item_t       pending_items[$];
    tmpg_pkg::result_t awaited_results[$];
    query_item_t       driven_item;

    int mismatches;
    int cycle_count;
    int holds_requested;
    int holds_done;

    // Enumerator state kept by the bench.
    logic [tmpg_pkg::CFG_W-1:0] trit_count;
    logic [tmpg_pkg::SIG_W-1:0] q_held;
    logic [tmpg_pkg::RAD_W-1:0] r_held;
    tmpg_pkg::phase_t           walk_phase;
    int                         pos_a;
    int                         pos_b;
    bit                         ch_a;
    bit                         ch_b;

    ternary_multiprobe_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock.
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Neighbour enumerator
    // ------------------------------------------------------------------------

    function automatic int live_trits();
        return (int'(trit_count) > TRIT_LIMIT) ? TRIT_LIMIT : int'(trit_count);
    endfunction

    function automatic logic [1:0] trit_of(logic [tmpg_pkg::SIG_W-1:0] s, int j);
        return s[2 * (j % 32) +: 2];
    endfunction

    function automatic logic [tmpg_pkg::SIG_W-1:0] with_trit(
        logic [tmpg_pkg::SIG_W-1:0] s, int j, logic [1:0] c);
        s[2 * (j % 32) +: 2] = c;
        return s;
    endfunction

    // Both 00 and 11 count as a zero trit.
    function automatic bit trit_is_zero(int j);
        logic [1:0] c;
        c = trit_of(q_held, j);
        return !(c == tmpg_pkg::CODE_POS || c == tmpg_pkg::CODE_NEG);
    endfunction

    // Cost-1 move: a zero trit goes to +1 or -1, a nonzero trit to zero.
    function automatic logic [1:0] moved_code(int j, bit choice);
        if (trit_is_zero(j))
            return choice ? tmpg_pkg::CODE_NEG : tmpg_pkg::CODE_POS;
        return tmpg_pkg::CODE_ZERO;
    endfunction

    function automatic int find_trit(int from, bit nonzero_only);
        for (int j = from; j < live_trits(); j++)
            if (!nonzero_only || !trit_is_zero(j))
                return j;
        return -1;
    endfunction

    function automatic logic [tmpg_pkg::SIG_W-1:0] probe_value();
        logic [tmpg_pkg::SIG_W-1:0] s;
        s = q_held;
        if (walk_phase == tmpg_pkg::PH_SINGLE) begin
            if (r_held == tmpg_pkg::RADIUS_SINGLE) begin
                s = with_trit(s, pos_a, moved_code(pos_a, ch_a));
            end else begin
                // Radius two opens with a sign flip of each nonzero trit.
                s = with_trit(s, pos_a,
                              (trit_of(s, pos_a) == tmpg_pkg::CODE_POS) ?
                              tmpg_pkg::CODE_NEG : tmpg_pkg::CODE_POS);
            end
        end else if (walk_phase == tmpg_pkg::PH_PAIR) begin
            s = with_trit(s, pos_a, moved_code(pos_a, ch_a));
            s = with_trit(s, pos_b, moved_code(pos_b, ch_b));
        end
        return s;
    endfunction

    function automatic bit open_pairs();
        if (live_trits() < 2)
            return 1'b0;
        walk_phase = tmpg_pkg::PH_PAIR;
        pos_a = 0;
        pos_b = 1;
        ch_a = 1'b0;
        ch_b = 1'b0;
        return 1'b1;
    endfunction

    function automatic bit open_single(int p);
        if (p < 0)
            return 1'b0;
        walk_phase = tmpg_pkg::PH_SINGLE;
        pos_a = p;
        ch_a = 1'b0;
        return 1'b1;
    endfunction

    // Pair order: second choice, first choice, second position, first position.
    function automatic bit next_pair_move();
        int n;
        n = live_trits();
        if (!ch_b && trit_is_zero(pos_b)) begin
            ch_b = 1'b1;
            return 1'b1;
        end
        if (!ch_a && trit_is_zero(pos_a)) begin
            ch_a = 1'b1;
            ch_b = 1'b0;
            return 1'b1;
        end
        ch_a = 1'b0;
        ch_b = 1'b0;
        if (pos_b + 1 < n) begin
            pos_b++;
            return 1'b1;
        end
        if (pos_a + 2 < n) begin
            pos_a++;
            pos_b = pos_a + 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit next_move();
        if (walk_phase == tmpg_pkg::PH_QUERY)
            return 1'b0;
        if (walk_phase == tmpg_pkg::PH_SINGLE) begin
            if (r_held == tmpg_pkg::RADIUS_SINGLE) begin
                if (!ch_a && trit_is_zero(pos_a)) begin
                    ch_a = 1'b1;
                    return 1'b1;
                end
                return open_single(find_trit(pos_a + 1, 1'b0));
            end
            if (open_single(find_trit(pos_a + 1, 1'b1)))
                return 1'b1;
            return open_pairs();
        end
        return next_pair_move();
    endfunction

    // Works out the result item of one accepted input item.
    function automatic tmpg_pkg::result_t enumerate_step(query_item_t it);
        tmpg_pkg::result_t r;
        bit                ok;
        r.probe = '0;
        r.kind  = tmpg_pkg::KIND_DONE;
        ok      = 1'b0;
        if (it.cmd == tmpg_pkg::CMD_START) begin
            q_held     = it.signature;
            r_held     = it.radius;
            walk_phase = tmpg_pkg::PH_IDLE;
            pos_a      = 0;
            pos_b      = 0;
            ch_a       = 1'b0;
            ch_b       = 1'b0;
            case (r_held)
                tmpg_pkg::RADIUS_QUERY: begin
                    walk_phase = tmpg_pkg::PH_QUERY;
                    ok = 1'b1;
                end
                tmpg_pkg::RADIUS_SINGLE: ok = open_single(find_trit(0, 1'b0));
                tmpg_pkg::RADIUS_PAIR: begin
                    ok = open_single(find_trit(0, 1'b1));
                    if (!ok)
                        ok = open_pairs();
                end
                default: ok = 1'b0;
            endcase
        end else if (walk_phase == tmpg_pkg::PH_IDLE) begin
            ok = 1'b0;
        end else if (it.prior_hit) begin
            walk_phase = tmpg_pkg::PH_IDLE;
            r.kind = tmpg_pkg::KIND_HIT;
            return r;
        end else begin
            ok = next_move();
        end
        if (ok) begin
            r.probe = probe_value();
            r.kind  = tmpg_pkg::KIND_PROBE;
        end else begin
            walk_phase = tmpg_pkg::PH_IDLE;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [tmpg_pkg::SIG_W-1:0] random_signature();
        logic [tmpg_pkg::SIG_W-1:0] s;
        int                         style;
        int                         k;
        style = $urandom_range(0, 5);
        case (style)
            0: s = {$urandom(), $urandom()};
            1: s = '0;
            2: s = '1;
            default: begin
                for (int j = 0; j < 32; j++) begin
                    if (style == 3) begin
                        s[2 * j +: 2] = 2'($urandom_range(0, 3));
                    end else if (style == 4) begin
                        // Mostly zero trits, both zero codes.
                        k = $urandom_range(0, 9);
                        if (k == 0)
                            s[2 * j +: 2] = tmpg_pkg::CODE_POS;
                        else if (k == 1)
                            s[2 * j +: 2] = tmpg_pkg::CODE_NEG;
                        else
                            s[2 * j +: 2] = k[0] ? 2'b11 : tmpg_pkg::CODE_ZERO;
                    end else begin
                        s[2 * j +: 2] = $urandom_range(0, 1) ?
                                        tmpg_pkg::CODE_POS : tmpg_pkg::CODE_NEG;
                    end
                end
            end
        endcase
        return s;
    endfunction

    function automatic void push_start(logic [tmpg_pkg::SIG_W-1:0] sig,
                                       logic [tmpg_pkg::RAD_W-1:0] rad);
        query_item_t it;
        it.cmd       = tmpg_pkg::CMD_START;
        it.signature = sig;
        it.radius    = rad;
        it.prior_hit = 1'($urandom_range(0, 1));
        pending_items.push_back(it);
    endfunction

    // Signature and radius of an advance are don't-care and get random bits.
    function automatic void push_advance(logic hit);
        query_item_t it;
        it.cmd       = tmpg_pkg::CMD_ADVANCE;
        it.signature = {$urandom(), $urandom()};
        it.radius    = 2'($urandom_range(0, 3));
        it.prior_hit = hit;
        pending_items.push_back(it);
    endfunction

    // One query run with random content; a few are loose noise items.
    function automatic int queue_sequence();
        int                         count;
        int                         n;
        int                         pick;
        logic [tmpg_pkg::RAD_W-1:0] rad;
        query_item_t                it;
        count = 0;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                it.cmd       = 1'($urandom_range(0, 1));
                it.signature = random_signature();
                it.radius    = 2'($urandom_range(0, 3));
                it.prior_hit = 1'($urandom_range(0, 1));
                pending_items.push_back(it);
                count++;
            end
            return count;
        end
        pick = $urandom_range(0, 19);
        if (pick < 2)
            rad = tmpg_pkg::RADIUS_QUERY;
        else if (pick < 10)
            rad = tmpg_pkg::RADIUS_SINGLE;
        else if (pick < 18)
            rad = tmpg_pkg::RADIUS_PAIR;
        else
            rad = 2'($urandom_range(3, 3));
        push_start(random_signature(), rad);
        count++;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 140) : $urandom_range(0, 30);
        repeat (n) begin
            push_advance(1'b0);
            count++;
        end
        // Close with a hit, leave it for the next start, or run past the end.
        case ($urandom_range(0, 3))
            0, 1: begin
                push_advance(1'b1);
                count++;
            end
            3: begin
                repeat ($urandom_range(1, 3)) begin
                    push_advance(1'($urandom_range(0, 1)));
                    count++;
                end
            end
            default: ;
        endcase
        return count;
    endfunction

    // Waits until no item is queued, offered or owed, plus the block's latency.
    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_trit_count(logic [tmpg_pkg::CFG_W-1:0] value);
        wait_quiet();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk);
        while (!cfg_ready);
        trit_count = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : sequencer
        logic [tmpg_pkg::CFG_W-1:0] phase_counts[10];
        int                         added;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        mismatches      = 0;
        holds_requested = 0;
        trit_count      = tmpg_pkg::TRITS_RESET;
        q_held          = '0;
        r_held          = '0;
        walk_phase      = tmpg_pkg::PH_IDLE;
        pos_a           = 0;
        pos_b           = 0;
        ch_a            = 1'b0;
        ch_b            = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Query radius, then advancing past it and while idle.
        push_start('1, tmpg_pkg::RADIUS_QUERY);
        push_advance(1'b0);
        push_advance(1'b1);
        // Radius three ends at once.
        push_start('0, 2'($urandom_range(3, 3)));
        // Radius one over +1, -1 and zeros, ended by a hit.
        push_start(64'h9, tmpg_pkg::RADIUS_SINGLE);
        push_advance(1'b0);
        push_advance(1'b0);
        push_advance(1'b1);
        // Sign flips, then a start that abandons the run.
        push_start({32{tmpg_pkg::CODE_POS}}, tmpg_pkg::RADIUS_PAIR);
        push_advance(1'b0);
        push_start(random_signature(), tmpg_pkg::RADIUS_SINGLE);
        push_advance(1'b0);
        // All-zero query goes straight to pairs.
        push_start('0, tmpg_pkg::RADIUS_PAIR);
        repeat (3) push_advance(1'b0);

        // No trits in use.
        write_trit_count(6'd0);
        push_start(random_signature(), tmpg_pkg::RADIUS_SINGLE);
        push_start(random_signature(), tmpg_pkg::RADIUS_PAIR);
        push_start(random_signature(), tmpg_pkg::RADIUS_QUERY);
        push_advance(1'b0);

        // One trit: no pairs exist.
        write_trit_count(6'd1);
        push_start('0, tmpg_pkg::RADIUS_PAIR);
        push_start('0, tmpg_pkg::RADIUS_SINGLE);
        push_advance(1'b0);
        push_advance(1'b0);

        // Above the trit limit saturates; the run then continues with a
        // smaller count written in its middle.
        write_trit_count(6'd63);
        push_start({32{tmpg_pkg::CODE_NEG}}, tmpg_pkg::RADIUS_PAIR);
        push_advance(1'b0);
        write_trit_count(6'd3);
        repeat (5) push_advance(1'b0);

        // Random runs under several trit counts.
        phase_counts = '{6'd32, 6'd2, 6'd63, 6'd5, 6'd0, 6'($urandom_range(0, 63)),
                         6'd1, 6'd32, 6'd3, 6'd4};
        for (int p = 0; p < 10; p++) begin
            write_trit_count(phase_counts[p]);
            added = 0;
            while (added < 120)
                added += queue_sequence();
            // Ask the receiver for a long hold while this phase streams in.
            if (p == 2 || p == 7)
                holds_requested++;
        end

        wait_quiet();
        repeat (8) @(posedge aclk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d result items never arrived",
                                      awaited_results.size()));
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: bursts of random length with random gaps.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin : driver
        bit offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(enumerate_step(driven_item));
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    driven_item = pending_items.pop_front();
                    offer = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                s_tvalid <= offer;
                if (offer) begin
                    s_tdata <= {5'b0, driven_item.prior_hit, driven_item.radius,
                                driven_item.signature};
                    s_tuser <= driven_item.cmd;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: changing stall styles, plus long holds on request.
    // ------------------------------------------------------------------------
    rx_style_t rx_style  = RX_OPEN;
    int        style_left = 0;
    int        hold_left  = 0;
    int        rx_tick    = 0;

    initial begin
        m_tready   = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        holds_done = 0;
    end

    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_done < holds_requested) begin
            holds_done++;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style   = rx_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(5, 60);
            end else begin
                style_left--;
            end
            rx_tick++;
            case (rx_style)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= (rx_tick % 4 == 0);
                default:   m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compares each accepted result with the oldest one owed.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        tmpg_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result probe %h kind %0d",
                                          m_tdata, m_tuser));
            end else begin
                want = awaited_results.pop_front();
                if (m_tdata !== want.probe)
                    report_mismatch($sformatf("probe_signature %h, expected %h",
                                              m_tdata, want.probe));
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("result_kind %0d, expected %0d",
                                              m_tuser, want.kind));
            end
        end
    end

    // Run limit.
    initial cycle_count = 0;

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/tmpg_pkg.sv
rtl/tmpg_step.sv
rtl/tmpg_out_skid.sv
rtl/ternary_multiprobe_generator.sv
sim/ternary_multiprobe_generator_tb.sv
